@@ src/fmpc_pkg.sv @@
`timescale 1ns / 1ps

package fmpc_pkg;

  // Rule table depth; one chain cell per rule.
  localparam int RULE_COUNT = 64;
  // Cell number width: wide enough for the table and for the 6-bit rule index.
  localparam int ID_W = (RULE_COUNT > 64) ? $clog2(RULE_COUNT) : 6;

  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 16;

  localparam logic [7:0] PROTO_NUM_ICMP = 8'd1;
  localparam logic [7:0] PROTO_NUM_TCP  = 8'd6;
  localparam logic [7:0] PROTO_NUM_UDP  = 8'd17;

  typedef enum logic [0:0] {
    ACT_WRITE    = 1'b0,
    ACT_CLASSIFY = 1'b1
  } act_e;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] src_mask;
    logic [31:0] dst_addr;
    logic [31:0] dst_mask;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  icmp_kind;
    logic [7:0]  verdict;
  } rule_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] verdict;
    logic [5:0] rule_number;
  } res_t;

  typedef struct packed {
    act_e       action;
    logic [5:0] rule_index;
    rule_t      rule;
    res_t       res;
  } item_t;

  // True when rule r accepts the packet key carried in k.
  function automatic logic rule_match(rule_t r, rule_t k);
    logic addr_ok;
    logic l4;
    logic port_ok;
    logic icmp_ok;
    addr_ok = ((r.src_mask & k.src_addr) == r.src_addr) &&
              ((r.dst_mask & k.dst_addr) == r.dst_addr);
    l4      = (k.protocol == PROTO_NUM_TCP) || (k.protocol == PROTO_NUM_UDP);
    port_ok = !l4 ||
              (((r.src_port == 16'd0) || (r.src_port == k.src_port)) &&
               ((r.dst_port == 16'd0) || (r.dst_port == k.dst_port)));
    icmp_ok = (k.protocol != PROTO_NUM_ICMP) ||
              (r.icmp_kind == 8'd0) || (r.icmp_kind == k.icmp_kind);
    return addr_ok &&
           ((r.protocol == 8'd0) || ((r.protocol == k.protocol) && port_ok && icmp_ok));
  endfunction

endpackage

@@ src/first_match_packet_classifier.sv @@
`timescale 1ns / 1ps

// Channel  Ports                            Carries
// in       in_tvalid/in_tready/in_tdata     rule write or packet key, in_tuser = action
//          in_tuser
// out      out_tvalid/out_tready/out_tdata  matched, verdict, rule_number
//
// Every beat walks a row of RULE_COUNT cells, one cell per cycle unless the row stalls.
// Each cell holds one rule. The row takes one beat per cycle unless stalled.
// Writes travel the row too and land at their cell, so beats keep their order.
// Reset clears the rule valid bits: every slot reads as the all-zero rule.
// A result waiting in the output register with another one behind it stalls the row.

module first_match_packet_classifier (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // rule_index, src_addr, src_mask, dst_addr, dst_mask, protocol, src_port,
  // dst_port, icmp_kind, rule_verdict, zero pad
  input  logic [fmpc_pkg::IN_DATA_W-1:0]     in_tdata,
  // action
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // matched, verdict, rule_number, zero pad
  output logic [fmpc_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import fmpc_pkg::*;

  logic  link_valid [RULE_COUNT+1];
  item_t link_item  [RULE_COUNT+1];
  logic  adv;
  logic  tail_cls;
  logic  out_valid_r;
  res_t  out_res_r;

  always_comb begin
    link_valid[0]                = in_tvalid;
    link_item[0].action          = act_e'(in_tuser);
    link_item[0].rule_index      = in_tdata[5:0];
    link_item[0].rule.src_addr   = in_tdata[37:6];
    link_item[0].rule.src_mask   = in_tdata[69:38];
    link_item[0].rule.dst_addr   = in_tdata[101:70];
    link_item[0].rule.dst_mask   = in_tdata[133:102];
    link_item[0].rule.protocol   = in_tdata[141:134];
    link_item[0].rule.src_port   = in_tdata[157:142];
    link_item[0].rule.dst_port   = in_tdata[173:158];
    link_item[0].rule.icmp_kind  = in_tdata[181:174];
    link_item[0].rule.verdict    = in_tdata[189:182];
    link_item[0].res             = '0;
  end

  for (genvar i = 0; i < RULE_COUNT; i++) begin : g_cell
    fmpc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_id  (ID_W'(i)),
      .up_valid (link_valid[i]),
      .up_item  (link_item[i]),
      .dn_valid (link_valid[i+1]),
      .dn_item  (link_item[i+1])
    );
  end

  // hold the row while a classify result at the tail cannot be stored
  assign tail_cls  = link_valid[RULE_COUNT] && (link_item[RULE_COUNT].action == ACT_CLASSIFY);
  assign adv       = !(tail_cls && out_valid_r && !out_tready);
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && tail_cls) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail_cls) begin
      out_res_r <= link_item[RULE_COUNT].res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.rule_number, out_res_r.verdict, out_res_r.hit};

  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[14:1] == 14'd0))
    else $error("miss result carries nonzero verdict or rule number");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(link_valid[RULE_COUNT]) && $stable(link_item[RULE_COUNT]))
    else $error("row moved while stalled");

endmodule

@@ src/fmpc_cell.sv @@
`timescale 1ns / 1ps

module fmpc_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic [fmpc_pkg::ID_W-1:0] cell_id,
  input  logic                     up_valid,
  input  fmpc_pkg::item_t          up_item,
  output logic                     dn_valid,
  output fmpc_pkg::item_t          dn_item
);
  import fmpc_pkg::*;

  rule_t rule_r;
  logic  rule_valid_r;
  logic  stage_valid_r;
  item_t stage_r;
  item_t stage_nxt;
  rule_t rule_eff;
  logic  wr_hit;
  logic  key_hit;

  always_comb begin
    // an unwritten slot is the all-zero rule
    rule_eff = rule_valid_r ? rule_r : '0;
    wr_hit   = up_valid && (up_item.action == ACT_WRITE) &&
               (ID_W'(up_item.rule_index) == cell_id);
    key_hit  = up_valid && (up_item.action == ACT_CLASSIFY) && !up_item.res.hit &&
               rule_match(rule_eff, up_item.rule);
    stage_nxt = up_item;
    if (key_hit) begin
      stage_nxt.res.hit         = 1'b1;
      stage_nxt.res.verdict     = rule_eff.verdict;
      stage_nxt.res.rule_number = cell_id[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_valid_r  <= 1'b0;
      stage_valid_r <= 1'b0;
    end else if (adv) begin
      stage_valid_r <= up_valid;
      if (wr_hit) begin
        rule_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_r <= stage_nxt;
      if (wr_hit) begin
        rule_r <= up_item.rule;
      end
    end
  end

  assign dn_valid = stage_valid_r;
  assign dn_item  = stage_r;

endmodule

@@ dv/first_match_packet_classifier_tb.sv @@
`timescale 1ns / 1ps

module first_match_packet_classifier_tb;
  import fmpc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_BEATS = 360;

  class acl_scoreboard;
    rule_t rules [RULE_COUNT];
    res_t  pending_verdicts [$];
    int    errors;

    function new();
      foreach (rules[i]) rules[i] = '0;
      errors = 0;
    endfunction

    function bit rule_hits(rule_t r, rule_t k);
      if ((r.src_mask & k.src_addr) != r.src_addr) return 1'b0;
      if ((r.dst_mask & k.dst_addr) != r.dst_addr) return 1'b0;
      // a wildcard protocol skips every layer four field
      if (r.protocol == 8'd0) return 1'b1;
      if (r.protocol != k.protocol) return 1'b0;
      if (k.protocol == PROTO_NUM_TCP || k.protocol == PROTO_NUM_UDP) begin
        if (r.src_port != 16'd0 && r.src_port != k.src_port) return 1'b0;
        if (r.dst_port != 16'd0 && r.dst_port != k.dst_port) return 1'b0;
      end
      if (k.protocol == PROTO_NUM_ICMP) begin
        if (r.icmp_kind != 8'd0 && r.icmp_kind != k.icmp_kind) return 1'b0;
      end
      return 1'b1;
    endfunction

    function res_t first_match_verdict(rule_t k);
      res_t v;
      v = '0;
      for (int i = 0; i < RULE_COUNT; i++) begin
        if (rule_hits(rules[i], k)) begin
          v.hit         = 1'b1;
          v.verdict     = rules[i].verdict;
          v.rule_number = 6'(i);
          return v;
        end
      end
      return v;
    endfunction

    function void note_beat(logic act, logic [IN_DATA_W-1:0] d);
      rule_t r;
      int    idx;
      idx         = int'(d[5:0]);
      r.src_addr  = d[37:6];
      r.src_mask  = d[69:38];
      r.dst_addr  = d[101:70];
      r.dst_mask  = d[133:102];
      r.protocol  = d[141:134];
      r.src_port  = d[157:142];
      r.dst_port  = d[173:158];
      r.icmp_kind = d[181:174];
      r.verdict   = d[189:182];
      if (act == ACT_CLASSIFY) pending_verdicts.push_back(first_match_verdict(r));
      else if (idx < RULE_COUNT) rules[idx] = r;
    endfunction

    function void flag(string field, int want, int got);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      res_t want;
      res_t got;
      got.hit         = d[0];
      got.verdict     = d[8:1];
      got.rule_number = d[14:9];
      if (pending_verdicts.size() == 0) begin
        flag("unexpected result, matched", -1, int'(got.hit));
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.hit != want.hit) flag("matched", int'(want.hit), int'(got.hit));
      if (got.verdict != want.verdict) flag("verdict", int'(want.verdict), int'(got.verdict));
      if (got.rule_number != want.rule_number)
        flag("rule_number", int'(want.rule_number), int'(got.rule_number));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  acl_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;

  first_match_packet_classifier u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check results before noting the beat accepted on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready) sb.note_beat(in_tuser, in_tdata);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic rule_t make_rule(logic [31:0] sa, logic [31:0] sm, logic [31:0] da,
                                      logic [31:0] dm, logic [7:0] proto, logic [15:0] sp,
                                      logic [15:0] dp, logic [7:0] icmp, logic [7:0] verd);
    rule_t r;
    r.src_addr  = sa;
    r.src_mask  = sm;
    r.dst_addr  = da;
    r.dst_mask  = dm;
    r.protocol  = proto;
    r.src_port  = sp;
    r.dst_port  = dp;
    r.icmp_kind = icmp;
    r.verdict   = verd;
    return r;
  endfunction

  function automatic logic [7:0] pick_protocol();
    case ($urandom_range(0, 4))
      0:       return PROTO_NUM_ICMP;
      1:       return PROTO_NUM_TCP;
      2:       return PROTO_NUM_UDP;
      3:       return 8'($urandom);
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [31:0] pick_mask();
    int len;
    len = $urandom_range(8, 32);
    case ($urandom_range(0, 19))
      0:       return 32'h0;
      1, 2:    return $urandom;
      default: return ~32'h0 << (32 - len);
    endcase
  endfunction

  function automatic rule_t random_rule();
    rule_t r;
    r.src_mask  = pick_mask();
    r.dst_mask  = pick_mask();
    r.src_addr  = $urandom & r.src_mask;
    r.dst_addr  = $urandom & r.dst_mask;
    // now and then leave address bits outside the mask
    if ($urandom_range(0, 19) == 0) r.src_addr = $urandom;
    if ($urandom_range(0, 19) == 0) r.dst_addr = $urandom;
    r.protocol  = pick_protocol();
    r.src_port  = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
    r.dst_port  = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
    r.icmp_kind = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
    r.verdict   = 8'($urandom);
    return r;
  endfunction

  function automatic rule_t random_key();
    rule_t k;
    k = random_rule();
    k.src_addr = $urandom;
    k.dst_addr = $urandom;
    k.src_mask = $urandom;
    k.dst_mask = $urandom;
    return k;
  endfunction

  // Build a key that hits the given slot, with an occasional near miss.
  function automatic rule_t key_for(int slot);
    rule_t r;
    rule_t k;
    r = sb.rules[slot];
    k = random_key();
    k.src_addr = ($urandom & ~r.src_mask) | r.src_addr;
    k.dst_addr = ($urandom & ~r.dst_mask) | r.dst_addr;
    k.protocol = (r.protocol != 8'd0) ? r.protocol : pick_protocol();
    if (r.src_port != 16'd0) k.src_port = r.src_port;
    if (r.dst_port != 16'd0) k.dst_port = r.dst_port;
    if (r.icmp_kind != 8'd0) k.icmp_kind = r.icmp_kind;
    case ($urandom_range(0, 9))
      0: k.dst_port ^= 16'h1 << $urandom_range(0, 15);
      1: k.icmp_kind ^= 8'h1 << $urandom_range(0, 7);
      2: k.src_addr ^= 32'h1 << $urandom_range(0, 31);
      default: ;
    endcase
    return k;
  endfunction

  // Enter and leave on a falling edge; hold the beat until it is taken.
  task automatic send_beat(input act_e act, input logic [5:0] idx, input rule_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = {2'b00, r.verdict, r.icmp_kind, r.dst_port, r.src_port, r.protocol,
                 r.dst_mask, r.dst_addr, r.src_mask, r.src_addr, idx};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (sb.pending_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int beats);
    int sent;
    sent = RULE_COUNT;
    for (int s = 0; s < RULE_COUNT; s++) send_beat(ACT_WRITE, 6'(s), random_rule());
    while (sent < beats) begin
      if ($urandom_range(0, 3) == 0)
        send_beat(ACT_WRITE, 6'($urandom), random_rule());
      else if ($urandom_range(0, 4) == 0)
        send_beat(ACT_CLASSIFY, 6'($urandom), random_key());
      else
        send_beat(ACT_CLASSIFY, 6'($urandom), key_for($urandom_range(0, RULE_COUNT - 1)));
      sent++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // cleared table: every slot is a match-all rule
    send_beat(ACT_CLASSIFY, 6'h3f, make_rule(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(ACT_CLASSIFY, 6'h00, make_rule('1, '1, '1, '1, '1, '1, '1, '1, '1));
    send_beat(ACT_WRITE, 6'h3f, make_rule('1, '1, '1, '1, '1, '1, '1, '1, '1));
    // source address outside its mask: never hits
    send_beat(ACT_WRITE, 6'h00, make_rule(32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0, 8'h11));
    send_beat(ACT_CLASSIFY, 6'h00, make_rule(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(ACT_WRITE, 6'h01, make_rule(32'h0a00_0000, 32'hff00_0000, 0, 0, PROTO_NUM_TCP,
                                          16'd0, 16'd80, 8'd0, 8'h22));
    send_beat(ACT_WRITE, 6'h02, make_rule(0, 0, 0, 0, PROTO_NUM_ICMP, 16'd1, 16'd2, 8'd8,
                                          8'h33));
    send_beat(ACT_WRITE, 6'h03, make_rule(0, 0, 32'hc0a8_0000, 32'hffff_0000, 8'd0,
                                          16'd1234, 16'd5678, 8'd9, 8'h44));
    send_beat(ACT_WRITE, 6'h04, make_rule(0, 0, 0, 0, PROTO_NUM_UDP, 16'd53, 16'd0, 8'd0,
                                          8'h55));
    send_beat(ACT_WRITE, 6'h05, make_rule(0, 0, 0, 0, 8'd50, '1, '1, '1, 8'h66));
    send_beat(ACT_WRITE, 6'h06, make_rule(32'hc000_0001, '1, 0, 0, PROTO_NUM_ICMP,
                                          0, 0, 0, 8'h77));
    send_beat(ACT_CLASSIFY, 6'h15, make_rule(32'h0a01_0203, '1, 0, 0, PROTO_NUM_TCP,
                                             16'd999, 16'd80, 8'd0, 0));
    send_beat(ACT_CLASSIFY, 6'h2a, make_rule(32'h0a01_0203, 0, 0, 0, PROTO_NUM_TCP,
                                             16'd999, 16'd81, 8'd0, 0));
    send_beat(ACT_CLASSIFY, 6'h00, make_rule(0, 0, 0, 0, PROTO_NUM_ICMP, 0, 0, 8'd8, 0));
    send_beat(ACT_CLASSIFY, 6'h3f, make_rule(32'hc000_0001, 0, 0, 0, PROTO_NUM_ICMP,
                                             0, 0, 8'd0, 0));
    send_beat(ACT_CLASSIFY, 6'h00, make_rule(0, 0, 32'hc0a8_0101, 0, PROTO_NUM_TCP,
                                             16'd7, 16'd7, 8'd0, 0));
    send_beat(ACT_CLASSIFY, 6'h00, make_rule(0, 0, 0, 0, PROTO_NUM_UDP, 16'd53, 16'd7, 0,
                                             0));
    send_beat(ACT_CLASSIFY, 6'h00, make_rule(0, 0, 0, 0, PROTO_NUM_UDP, 16'd54, 16'd7, 0,
                                             0));
    send_beat(ACT_CLASSIFY, 6'h00, make_rule(0, 0, 0, 0, 8'd50, 0, 0, 0, 0));
    send_beat(ACT_CLASSIFY, 6'h00, make_rule(32'h0a00_0000, 0, 0, 0, PROTO_NUM_TCP,
                                             0, 0, 0, 0));
    drain_results();

    send_idle_pct = 28;
    recv_idle_pct = 46;
    run_phase(PHASE_BEATS);
    drain_results();

    send_idle_pct = 46;
    recv_idle_pct = 28;
    run_phase(PHASE_BEATS);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(PHASE_BEATS);
    drain_results();

    // let writes still in the row flush and catch any stray result
    repeat (4 * RULE_COUNT) @(posedge clk);
    if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/fmpc_pkg.sv
src/fmpc_cell.sv
src/first_match_packet_classifier.sv
dv/first_match_packet_classifier_tb.sv
